>>> src/ptzcfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptzcfe_pkg
// Shared types and constants of the PTZ command frame encoder.
// ----------------------------------------------------------------------------
package ptzcfe_pkg;

	localparam int PRESET_ENTRIES = 195;
	localparam int PRESET_IDX_W   = (PRESET_ENTRIES > 1) ? $clog2(PRESET_ENTRIES) : 1;
	localparam int FRAME_LEN      = 9;
	localparam int CNT_W          = $clog2(FRAME_LEN);

	localparam logic [7:0] SYNC_BYTE   = 8'hFF;
	localparam logic [7:0] FORCED_ADDR = 8'h01;
	localparam logic [7:0] BYTE_CR     = 8'h0D;
	localparam logic [7:0] BYTE_LF     = 8'h0A;
	localparam logic [7:0] BAND_0      = 8'h3D;
	localparam logic [7:0] BAND_1      = 8'h3E;
	localparam logic [7:0] BAND_2      = 8'h3F;
	localparam logic [7:0] BAND_3      = 8'h40;
	localparam logic [7:0] AUTOSCAN_D2 = 8'h26;
	localparam logic [7:0] VSCAN_D2    = 8'h27;
	localparam logic [7:0] RESET_D2    = 8'h28;

	typedef enum logic [3:0] {
		OP_STOP       = 4'd0,
		OP_LEFT       = 4'd1,
		OP_RIGHT      = 4'd2,
		OP_UP         = 4'd3,
		OP_DOWN       = 4'd4,
		OP_SCANSPEED  = 4'd5,
		OP_AUTOSCAN   = 4'd6,
		OP_SETPRESET  = 4'd7,
		OP_DWELL      = 4'd8,
		OP_CALLPRESET = 4'd9,
		OP_CLEARLINE  = 4'd10,
		OP_GETPRESET  = 4'd11,
		OP_RESET      = 4'd12,
		OP_VSCAN      = 4'd13,
		OP_DELPRESET  = 4'd14,
		OP_INVALID    = 4'd15
	} op_t;

	typedef struct packed {
		logic [FRAME_LEN-1:0][7:0] bytes;
		logic                      in_range;
		logic                      mark;
	} frame_t;

endpackage

>>> src/ptzcfe_frame_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptzcfe_frame_build
// Builds the nine frame bytes, checksum and preset status of one command.
// ----------------------------------------------------------------------------
module ptzcfe_frame_build
	import ptzcfe_pkg::*;
(
	input  op_t        operation,
	input  logic [7:0] channel,
	input  logic [7:0] speed,
	input  logic [7:0] extra_arg,
	input  logic       stored_mark,
	output frame_t     frame,
	output logic       frame_ok
);

	logic [7:0] addr;
	logic [7:0] cmd1;
	logic [7:0] cmd2;
	logic [7:0] data1;
	logic [7:0] data2;
	logic [7:0] band;
	logic [7:0] csum;
	logic       in_range;

	assign in_range = ({1'b0, speed} < 9'(PRESET_ENTRIES));

	always_comb begin
		if (speed < 8'd16) begin
			band = BAND_0;
		end else if (speed < 8'd32) begin
			band = BAND_1;
		end else if (speed < 8'd48) begin
			band = BAND_2;
		end else begin
			band = BAND_3;
		end
	end

	always_comb begin
		addr     = channel;
		cmd1     = 8'h00;
		cmd2     = 8'h00;
		data1    = 8'h00;
		data2    = 8'h00;
		frame_ok = 1'b1;
		unique case (operation)
			OP_STOP: begin
			end
			OP_LEFT: begin
				cmd2  = 8'h04;
				data1 = speed;
			end
			OP_RIGHT: begin
				cmd2  = 8'h02;
				data1 = speed;
			end
			OP_UP: begin
				cmd2  = 8'h08;
				data2 = speed;
			end
			OP_DOWN: begin
				cmd2  = 8'h10;
				data2 = speed;
			end
			OP_SCANSPEED: begin
				addr  = FORCED_ADDR;
				cmd2  = 8'h03;
				data2 = band;
			end
			OP_AUTOSCAN: begin
				addr  = FORCED_ADDR;
				cmd2  = 8'h07;
				data1 = speed;
				data2 = AUTOSCAN_D2;
			end
			OP_SETPRESET: begin
				cmd2  = 8'h03;
				data1 = speed;
			end
			OP_DWELL: begin
				cmd2  = 8'h03;
				data2 = speed;
			end
			OP_CALLPRESET: begin
				cmd2  = 8'h07;
				data1 = speed;
			end
			OP_CLEARLINE: begin
				cmd2  = 8'h07;
				data1 = extra_arg;
				data2 = speed;
			end
			OP_GETPRESET: begin
				cmd1  = 8'h01;
				cmd2  = 8'h01;
				data1 = 8'h01;
				data2 = 8'h01;
			end
			OP_RESET: begin
				cmd2  = 8'h03;
				data2 = RESET_D2;
			end
			OP_VSCAN: begin
				addr  = FORCED_ADDR;
				cmd2  = 8'h07;
				data1 = speed;
				data2 = VSCAN_D2;
			end
			OP_DELPRESET: begin
				addr  = FORCED_ADDR;
				cmd2  = 8'h05;
				data2 = speed;
			end
			OP_INVALID: begin
				frame_ok = 1'b0;
			end
			default: begin
				frame_ok = 1'b0;
			end
		endcase
	end

	assign csum = addr + cmd1 + cmd2 + data1 + data2;

	always_comb begin
		frame.bytes[0] = SYNC_BYTE;
		frame.bytes[1] = addr;
		frame.bytes[2] = cmd1;
		frame.bytes[3] = cmd2;
		frame.bytes[4] = data1;
		frame.bytes[5] = data2;
		frame.bytes[6] = csum;
		frame.bytes[7] = BYTE_CR;
		frame.bytes[8] = BYTE_LF;
		frame.in_range = in_range;
		if (!in_range) begin
			frame.mark = 1'b0;
		end else if (operation == OP_SETPRESET) begin
			frame.mark = 1'b1;
		end else if (operation == OP_DELPRESET) begin
			frame.mark = 1'b0;
		end else begin
			frame.mark = stored_mark;
		end
	end

endmodule

>>> src/ptz_command_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptz_command_frame_encoder
// Turns pan/tilt command items into nine-byte serial frames, one frame per valid item.
// ----------------------------------------------------------------------------
// Each command is registered, decoded into a full frame and then shifted out
// one byte per cycle while m_axis_tready is high; tlast marks the ninth byte.
// A new frame is loaded only as the last byte of the previous one is taken,
// so the byte serializer sets the command rate; the next command waits in the
// input register meanwhile. An accepted command passes the input register and
// then enters the output shift register, which presents its first byte.
// Invalid commands are dropped without output. Preset marks live in a one-bit
// memory of PRESET_ENTRIES entries; after reset a clearing pass writes every
// entry to zero, holding s_axis_tready low until the last entry is written.
// The mark of the addressed preset is read when a command is accepted, with
// the update of the frame being loaded in the same cycle forwarded.
// tuser reports in-range and the mark after the update.
// ----------------------------------------------------------------------------
module ptz_command_frame_encoder
	import ptzcfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // operation[3:0], channel[11:4], speed[19:12],
	                                   // extra_arg[27:20], zero[31:28]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // frame_byte[7:0]
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser   // preset_in_range[0], preset_mark[1]
);

	logic                      valid_s1;
	op_t                       op_s1;
	logic [7:0]                channel_s1;
	logic [7:0]                speed_s1;
	logic [7:0]                extra_s1;
	logic                      mark_s1;

	logic                      marks_mem [PRESET_ENTRIES];
	logic                      clearing_q;
	logic [PRESET_IDX_W-1:0]   clr_q;
	logic [PRESET_IDX_W-1:0]   idx;
	logic                      stored_mark;
	logic                      in_fire;
	logic [PRESET_IDX_W-1:0]   rd_idx;
	logic                      rd_in_range;
	logic                      mark_we;
	logic                      wr_en;
	logic [PRESET_IDX_W-1:0]   wr_idx;
	logic                      wr_bit;

	frame_t                    frame;
	logic                      frame_ok;

	logic                      busy_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [FRAME_LEN-1:0][7:0] bytes_q;
	logic                      in_range_q;
	logic                      mark_q;

	logic                      out_fire;
	logic                      last;
	logic                      frame_free;
	logic                      load;
	logic                      adv;

	assign idx         = speed_s1[PRESET_IDX_W-1:0];
	assign stored_mark = mark_s1;

	ptzcfe_frame_build u_build (
		.operation   (op_s1),
		.channel     (channel_s1),
		.speed       (speed_s1),
		.extra_arg   (extra_s1),
		.stored_mark (stored_mark),
		.frame       (frame),
		.frame_ok    (frame_ok)
	);

	assign last          = (cnt_q == CNT_W'(FRAME_LEN - 1));
	assign out_fire      = busy_q && m_axis_tready;
	assign frame_free    = !busy_q || (out_fire && last);
	assign load          = valid_s1 && frame_ok && frame_free;
	assign adv           = valid_s1 && (!frame_ok || frame_free);
	assign s_axis_tready = !clearing_q && (!valid_s1 || adv);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign rd_idx      = s_axis_tdata[12 +: PRESET_IDX_W];
	assign rd_in_range = ({1'b0, s_axis_tdata[19:12]} < 9'(PRESET_ENTRIES));
	assign mark_we     = load && frame.in_range &&
	                     ((op_s1 == OP_SETPRESET) || (op_s1 == OP_DELPRESET));
	assign wr_en       = clearing_q || mark_we;
	assign wr_idx      = clearing_q ? clr_q : idx;
	assign wr_bit      = !clearing_q && (op_s1 == OP_SETPRESET);

	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = bytes_q[0];
	assign m_axis_tlast  = last;
	assign m_axis_tuser  = {mark_q, in_range_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1      <= op_t'(s_axis_tdata[3:0]);
			channel_s1 <= s_axis_tdata[11:4];
			speed_s1   <= s_axis_tdata[19:12];
			extra_s1   <= s_axis_tdata[27:20];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == PRESET_IDX_W'(PRESET_ENTRIES - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + PRESET_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			marks_mem[wr_idx] <= wr_bit;
		end
		if (in_fire) begin
			if (!rd_in_range) begin
				mark_s1 <= 1'b0;
			end else if (mark_we && (idx == rd_idx)) begin
				mark_s1 <= wr_bit;
			end else begin
				mark_s1 <= marks_mem[rd_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (out_fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q    <= frame.bytes;
			in_range_q <= frame.in_range;
			mark_q     <= frame.mark;
		end else if (out_fire) begin
			bytes_q <= {8'h00, bytes_q[FRAME_LEN-1:1]};
		end
	end

endmodule
